/* rtl/mwg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwg_pkg
// Shared types and constants of the multi-mode test waveform generator.
// ----------------------------------------------------------------------------
package mwg_pkg;

    // Waveform modes; codes five to seven are undefined and give zero
    typedef enum logic [2:0] {
        MODE_DC    = 3'd0,
        MODE_RAMP  = 3'd1,
        MODE_SINE  = 3'd2,
        MODE_TRI   = 3'd3,
        MODE_PULSE = 3'd4
    } mode_t;

    // Configuration port geometry
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MODE         = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DC_LEVEL     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_INCREMENT    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RAMP_LIMIT   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_NEGATE       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_OFFSET = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_DUTY         = 3'd7;

    // Register reset values
    localparam logic [30:0] RAMP_LIMIT_RST = 31'd2147418;
    localparam logic [31:0] AMPLITUDE_RST  = 32'd2147418;
    localparam logic [31:0] DUTY_RST       = 32'h8000_0000;

    // pi/2 in Q2.30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Sample range limits
    localparam logic signed [33:0] SAT_MAX = 34'sh0_7FFF_FFFF;
    localparam logic signed [33:0] SAT_MIN = -34'sh0_8000_0000;

    // Configuration register file contents
    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] dc_level;
        logic [31:0] increment;
        logic [30:0] ramp_limit;
        logic        negate;
        logic [31:0] amplitude;
        logic [31:0] level_offset;
        logic [31:0] duty;
    } cfg_t;

    // First pipeline stage word, front end to back end
    typedef struct packed {
        logic        valid;
        logic [2:0]  mode;
        logic [31:0] rom;
        logic [32:0] tri_f;
        logic [31:0] ramp_val;
        logic        pulse_hi;
    } stage1_t;

endpackage

/* rtl/mwg_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwg_in_if
// Tick channel: one word per time step, carrying the restart flag.
// ----------------------------------------------------------------------------
interface mwg_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

/* rtl/mwg_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwg_out_if
// Result channel: one signed Q16.16 sample per word.
// ----------------------------------------------------------------------------
interface mwg_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

/* rtl/mwg_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwg_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module mwg_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [mwg_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mwg_pkg::CFG_DATA_W-1:0]    cfg_data,
    output mwg_pkg::cfg_t                     cfg
);
    import mwg_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Merge the written word into the addressed register
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:         cfg_next.mode         = cfg_data[2:0];
                REG_DC_LEVEL:     cfg_next.dc_level     = cfg_data;
                REG_INCREMENT:    cfg_next.increment    = cfg_data;
                REG_RAMP_LIMIT:   cfg_next.ramp_limit   = cfg_data[30:0];
                REG_NEGATE:       cfg_next.negate       = cfg_data[0];
                REG_AMPLITUDE:    cfg_next.amplitude    = cfg_data;
                REG_LEVEL_OFFSET: cfg_next.level_offset = cfg_data;
                REG_DUTY:         cfg_next.duty         = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode         <= MODE_DC;
            cfg_reg.dc_level     <= '0;
            cfg_reg.increment    <= '0;
            cfg_reg.ramp_limit   <= RAMP_LIMIT_RST;
            cfg_reg.negate       <= 1'b0;
            cfg_reg.amplitude    <= AMPLITUDE_RST;
            cfg_reg.level_offset <= '0;
            cfg_reg.duty         <= DUTY_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/mwg_sine_rom.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwg_sine_rom
// Full-period sine table in Q1.30, built at elaboration, registered read.
// ----------------------------------------------------------------------------
module mwg_sine_rom #(
    parameter int TABLE_BITS = 10
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic [TABLE_BITS-1:0] addr,
    output logic [31:0]           data
);
    import mwg_pkg::*;

    localparam int ROM_SIZE = 1 << TABLE_BITS;
    localparam int QUARTER  = ROM_SIZE >> 2;
    localparam int Q_SHIFT  = TABLE_BITS - 2;

    typedef logic [31:0] rom_t [ROM_SIZE];

    // sin(pi/2 * r / QUARTER) by Taylor series to x^13, floored Q30 terms
    function automatic logic signed [63:0] quarter_sine(input logic [TABLE_BITS-2:0] r);
        logic        [63:0] x;
        logic        [63:0] x2;
        logic        [63:0] term;
        logic signed [63:0] sum;
        x    = (HALF_PI_Q30 * 64'(r)) >> Q_SHIFT;
        x2   = (x * x) >> 30;
        sum  = $signed(x);
        term = ((x * x2) >> 30) / 64'd6;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + $signed(term);
        if (sum < 0)
            sum = 0;
        if (sum > 64'sd1073741824)
            sum = 64'sd1073741824;
        return sum;
    endfunction

    // Unfold the quarter wave over four quadrants
    function automatic rom_t build_rom();
        rom_t                    rom;
        logic [1:0]              quad;
        logic [TABLE_BITS-2:0]   r;
        logic signed [63:0]      s;
        for (int k = 0; k < ROM_SIZE; k++)
        begin
            quad = 2'(k >> Q_SHIFT);
            r    = (TABLE_BITS-1)'(k & (QUARTER - 1));
            s    = quad[0] ? quarter_sine((TABLE_BITS-1)'(QUARTER - int'(r)))
                           : quarter_sine(r);
            rom[k] = quad[1] ? 32'(-s) : 32'(s);
        end
        return rom;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic [31:0] data_reg;

    // Read on demand, hold otherwise
    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= SINE_ROM[addr];
    end

    assign data = data_reg;

endmodule

/* rtl/mwg_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwg_front
// Tick acceptance, phase accumulator and ramp level, first pipeline stage.
// ----------------------------------------------------------------------------
module mwg_front #(
    parameter int TABLE_BITS = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    input  mwg_pkg::cfg_t    cfg,
    mwg_in_if.sink           tick,
    input  logic             take1,
    output mwg_pkg::stage1_t s1
);
    import mwg_pkg::*;

    logic [31:0] phase_acc_reg;
    logic [31:0] phase_acc_next;
    logic [30:0] ramp_level_reg;
    logic [30:0] ramp_level_next;
    logic        v1_reg;
    logic [2:0]  mode_reg;
    logic [32:0] tri_f_reg;
    logic [31:0] ramp_val_reg;
    logic        pulse_hi_reg;

    logic               accept;
    logic [31:0]        phase;
    logic [30:0]        level;
    logic [32:0]        ramp_sum;
    logic [30:0]        ramp_lvl;
    logic signed [33:0] two_p;
    logic signed [33:0] tri_wide;
    logic [31:0]        rom_data;

    assign tick.ready = !v1_reg || take1;
    assign accept     = tick.valid && tick.ready;

    // Clear state first on restart
    assign phase = tick.restart ? '0 : phase_acc_reg;
    assign level = tick.restart ? '0 : ramp_level_reg;

    // Ramp step with wrap to zero past the limit
    assign ramp_sum = 33'(level) + 33'(cfg.increment);
    assign ramp_lvl = (ramp_sum > 33'(cfg.ramp_limit)) ? '0 : ramp_sum[30:0];

    // Triangle fold of the phase
    assign two_p    = $signed({2'b00, phase} << 1);
    assign tri_wide = (phase <= 32'h8000_0000) ? two_p - 34'sh0_8000_0000
                                               : 34'sh1_8000_0000 - two_p;

    // State update per accepted tick
    always_comb
    begin
        phase_acc_next  = phase_acc_reg;
        ramp_level_next = ramp_level_reg;
        if (accept)
        begin
            phase_acc_next  = phase;
            ramp_level_next = level;
            if (cfg.mode == MODE_RAMP)
                ramp_level_next = ramp_lvl;
            if (cfg.mode == MODE_SINE || cfg.mode == MODE_TRI || cfg.mode == MODE_PULSE)
                phase_acc_next = phase + cfg.increment;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg  <= '0;
            ramp_level_reg <= '0;
            v1_reg         <= 1'b0;
        end
        else
        begin
            phase_acc_reg  <= phase_acc_next;
            ramp_level_reg <= ramp_level_next;
            if (tick.ready)
                v1_reg <= accept;
        end
    end

    // Capture the stage word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg     <= cfg.mode;
            tri_f_reg    <= tri_wide[32:0];
            ramp_val_reg <= cfg.negate ? 32'(-{1'b0, ramp_lvl}) : {1'b0, ramp_lvl};
            pulse_hi_reg <= (phase <= cfg.duty);
        end
    end

    mwg_sine_rom #(
        .TABLE_BITS (TABLE_BITS)
    ) u_rom (
        .clk  (clk),
        .en   (accept),
        .addr (phase[31 -: TABLE_BITS]),
        .data (rom_data)
    );

    assign s1.valid    = v1_reg;
    assign s1.mode     = mode_reg;
    assign s1.rom      = rom_data;
    assign s1.tri_f    = tri_f_reg;
    assign s1.ramp_val = ramp_val_reg;
    assign s1.pulse_hi = pulse_hi_reg;

endmodule

/* rtl/mwg_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwg_back
// Amplitude scaling, rounding, offset, saturation and the output register.
// ----------------------------------------------------------------------------
module mwg_back (
    input  logic             clk,
    input  logic             rst_n,
    input  mwg_pkg::cfg_t    cfg,
    input  mwg_pkg::stage1_t s1,
    output logic             take1,
    mwg_out_if.source        result
);
    import mwg_pkg::*;

    logic               v2_reg;
    logic               v3_reg;
    logic               vo_reg;
    logic [2:0]         mode2_reg;
    logic [2:0]         mode3_reg;
    logic signed [64:0] prod_reg;
    logic signed [32:0] scaled_reg;
    logic [31:0]        ramp2_reg;
    logic [31:0]        ramp3_reg;
    logic               pulse2_reg;
    logic               pulse3_reg;
    logic [31:0]        sample_reg;
    logic [31:0]        sample_next;

    logic               adv2;
    logic               adv3;
    logic               advo;
    logic signed [32:0] operand;
    logic               neg;
    logic [63:0]        mag;
    logic [63:0]        mag_rnd;
    logic [31:0]        mag_q;
    logic signed [32:0] addend;
    logic signed [33:0] sum;
    logic [31:0]        sat_val;

    // Stage moves when the next one is empty or moving
    assign advo  = !vo_reg || result.ready;
    assign adv3  = !v3_reg || advo;
    assign adv2  = !v2_reg || adv3;
    assign take1 = adv2;

    // Multiply by the sine entry or the triangle fold
    assign operand = (s1.mode == MODE_SINE) ? $signed({s1.rom[31], s1.rom})
                                            : $signed(s1.tri_f);

    // Round magnitude to nearest, ties away from zero
    assign neg     = prod_reg[64];
    assign mag     = neg ? 64'(-prod_reg) : 64'(prod_reg);
    assign mag_rnd = (mode2_reg == MODE_SINE) ? (mag + (64'd1 << 29)) >> 30
                                              : (mag + (64'd1 << 31)) >> 32;
    assign mag_q   = mag_rnd[31:0];

    // Add offset and saturate
    assign addend = (mode3_reg == MODE_PULSE) ? $signed({cfg.amplitude[31], cfg.amplitude})
                                              : scaled_reg;
    assign sum    = 34'(addend) + 34'($signed(cfg.level_offset));
    always_comb
    begin
        priority if (sum > SAT_MAX)
            sat_val = SAT_MAX[31:0];
        else if (sum < SAT_MIN)
            sat_val = SAT_MIN[31:0];
        else
            sat_val = sum[31:0];
    end

    // Select the sample by mode
    always_comb
    begin
        unique case (mode3_reg)
            MODE_DC:    sample_next = cfg.dc_level;
            MODE_RAMP:  sample_next = ramp3_reg;
            MODE_SINE:  sample_next = sat_val;
            MODE_TRI:   sample_next = sat_val;
            MODE_PULSE: sample_next = pulse3_reg ? sat_val : '0;
            default:    sample_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (adv2)
                v2_reg <= s1.valid;
            if (adv3)
                v3_reg <= v2_reg;
            if (advo)
                vo_reg <= v3_reg;
        end
    end

    // Advance payload through the stages
    always_ff @(posedge clk)
    begin
        if (adv2 && s1.valid)
        begin
            prod_reg   <= $signed(cfg.amplitude) * operand;
            mode2_reg  <= s1.mode;
            ramp2_reg  <= s1.ramp_val;
            pulse2_reg <= s1.pulse_hi;
        end
        if (adv3 && v2_reg)
        begin
            scaled_reg <= neg ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
            mode3_reg  <= mode2_reg;
            ramp3_reg  <= ramp2_reg;
            pulse3_reg <= pulse2_reg;
        end
        if (advo && v3_reg)
            sample_reg <= sample_next;
    end

    assign result.valid  = vo_reg;
    assign result.sample = sample_reg;

endmodule

/* rtl/multi_mode_test_waveform_generator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_mode_test_waveform_generator_core
// Multi-mode test waveform generator: dc, ramp, sine, triangle and pulse.
// ----------------------------------------------------------------------------
// Each tick word yields one signed Q16.16 sample word. The block takes one
// tick per clock unless a stalled result has filled the stages. The tick
// edge updates the phase accumulator and ramp level and reads the sine
// table (2^SINE_TABLE_BITS x 32 single-port memory, registered read), then
// one stage multiplies by the amplitude, one rounds, and one adds the offset,
// saturates and holds the sample in the output register. Every stage has its
// own valid bit, so a stalled result only stops the stages behind it once
// they fill. The user must write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module multi_mode_test_waveform_generator_core #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                            clk,
    input  logic                            rst_n,
    mwg_in_if.sink                          tick,
    mwg_out_if.source                       result,
    input  logic                            cfg_we,
    input  logic [mwg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mwg_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import mwg_pkg::*;

    cfg_t    cfg;
    stage1_t s1;
    logic    take1;

    mwg_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mwg_front #(
        .TABLE_BITS (SINE_TABLE_BITS)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .tick  (tick),
        .take1 (take1),
        .s1    (s1)
    );

    mwg_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .s1     (s1),
        .take1  (take1),
        .result (result)
    );

endmodule

/* rtl/mwg_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwg_checker
// Port-level checks of the waveform generator, bound to the top level.
// ----------------------------------------------------------------------------
module mwg_checker (
    input logic clk,
    input logic rst_n,
    input logic tick_valid,
    input logic tick_ready,
    input logic result_valid,
    input logic result_ready
);
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic       tick_acc;
    logic       result_acc;

    assign tick_acc   = tick_valid && tick_ready;
    assign result_acc = result_valid && result_ready;

    // Track words in flight
    always_comb
    begin
        count_next = count_reg;
        if (tick_acc && !result_acc)
            count_next = count_reg + 3'd1;
        else if (!tick_acc && result_acc)
            count_next = count_reg - 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // A result is never delivered without a tick behind it
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        result_acc |-> count_reg != 3'd0)
        else $error("result delivered with no tick in flight");

    // The pipeline never holds more than its four stages
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'd4)
        else $error("more words in flight than pipeline stages");

    // An empty output register never blocks ticks
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> tick_ready)
        else $error("tick stalled while output register empty");

    // A stalled result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped while stalled");

endmodule

bind multi_mode_test_waveform_generator_core mwg_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .tick_valid   (tick.valid),
    .tick_ready   (tick.ready),
    .result_valid (result.valid),
    .result_ready (result.ready)
);
